>>> rtl/stack_vm_instruction_step_macros.svh
// ----------------------------------------------------------------------------
// Stack VM step: assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STACK_VM_INSTRUCTION_STEP_MACROS_SVH
`define STACK_VM_INSTRUCTION_STEP_MACROS_SVH

// same-cycle implication
`define SVIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/svis_pkg.sv
// ----------------------------------------------------------------------------
// svis_pkg
// Types and constants shared by the stack VM step controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svis_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam int IO_WORD_W   = 32;
  localparam int LOAD_ADDR_W = 9;
  localparam int CHAR_W      = 8;
  localparam int OP_COUNT    = 12;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_A  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PC = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SP = 3'd5;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_ADD     = 4'd2,
    OP_SUB     = 4'd3,
    OP_SET     = 4'd4,
    OP_MOVE    = 4'd5,
    OP_CALL    = 4'd6,
    OP_RET     = 4'd7,
    OP_BRZ     = 4'd8,
    OP_HALT    = 4'd9,
    OP_OUT     = 4'd10,
    OP_OUTC    = 4'd11,
    OP_UNKNOWN = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_REG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_OPER_A,
    S_OPER_B
  } state_t;

  typedef struct packed {
    logic                   command;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic signed [IO_WORD_W-1:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic                        out_valid;
    logic                        out_is_char;
    logic signed [IO_WORD_W-1:0] out_value;
    logic                        halted;
    logic [1:0]                  status;
  } res_t;

  typedef struct packed {
    logic load_we;
    logic clear_status;
    logic pc_inc;
    logic latch_op;
    logic stk_pop;
    logic latch_a;
    logic exec;
    logic halt;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op_dec;
    opcode_t op_q;
    logic    running;
    logic    clearing;
    logic    pend_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/svis_ctrl.sv
// ----------------------------------------------------------------------------
// svis_ctrl
// Sequencer: accept, decode, operand fetch and execute for one instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stack_vm_instruction_step_macros.svh"

module svis_ctrl
  import svis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  input  wire logic      command,
  output logic           cmd_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      ctl
);

  state_t state, state_next;
  logic   take;

  assign take = cmd_valid && !stat.clearing && !stat.pend_busy && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    cmd_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = !stat.clearing && !stat.pend_busy;
        if (take) begin
          ctl.clear_status = 1'b1;
          if (command == CMD_LOAD) begin
            ctl.load_we = 1'b1;
            ctl.finish  = 1'b1;
          end else if (!stat.running) begin
            ctl.finish = 1'b1;
          end else begin
            ctl.pc_inc = 1'b1;
            state_next = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        ctl.latch_op = 1'b1;
        unique case (stat.op_dec)
          OP_HALT: begin
            ctl.halt   = 1'b1;
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
          OP_UNKNOWN: begin
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
          OP_POP: begin
            ctl.pc_inc  = 1'b1;
            ctl.stk_pop = 1'b1;
            state_next  = S_OPER_A;
          end
          OP_RET: begin
            ctl.stk_pop = 1'b1;
            state_next  = S_OPER_A;
          end
          default: begin
            ctl.pc_inc = 1'b1;
            state_next = S_OPER_A;
          end
        endcase
      end
      S_OPER_A: begin
        if (stat.op_q == OP_SET || stat.op_q == OP_MOVE) begin
          ctl.latch_a = 1'b1;
          ctl.pc_inc  = 1'b1;
          state_next  = S_OPER_B;
        end else begin
          ctl.exec   = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OPER_B: begin
        ctl.exec   = 1'b1;
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SVIS_ASSERT_NEXT(a_step_decodes, take && (command == CMD_STEP) && stat.running, state == S_DECODE, "running step did not enter decode")
  `SVIS_ASSERT_IMPL(a_oper_b_order, state == S_OPER_B, $past(state) == S_OPER_A, "second operand without first")
  `SVIS_ASSERT_IMPL(a_no_take_clear, stat.clearing, !cmd_ready, "word taken during stack clear")

endmodule

`default_nettype wire

>>> rtl/svis_dpath.sv
// ----------------------------------------------------------------------------
// svis_dpath
// Register file, program and stack memories, execute logic, result staging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stack_vm_instruction_step_macros.svh"

module svis_dpath
  import svis_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 512,
  parameter int STACK_DEPTH   = 256,
  parameter int WORD_WIDTH    = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd,
  input  wire ctrl_cmd_t ctl,
  output dp_stat_t       stat,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_t           res
);

  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int WW  = WORD_WIDTH;
  localparam logic [WW-1:0]  NUM_REGS_W = WW'(NUM_REGS);
  localparam logic [WW-1:0]  OP_LIMIT   = WW'(OP_COUNT);
  localparam logic [SAW-1:0] STK_LAST   = SAW'(STACK_DEPTH - 1);
  localparam logic [REG_IDX_W-1:0] NUM_REGS_I = REG_IDX_W'(NUM_REGS);

  logic [WW-1:0] pmem [PROGRAM_DEPTH];
  logic [WW-1:0] prd;
  logic [WW-1:0] smem [STACK_DEPTH];
  logic [WW-1:0] srd;
  logic [WW-1:0] regs [NUM_REGS];

  logic [WW-1:0] pc, sp, acc, pc_plus, sp_plus, sp_minus;
  logic [WW-1:0] a_q;
  opcode_t       op_q, op_dec;
  status_t       status_q, status_now;
  logic          running;
  logic          clearing;
  logic [SAW-1:0] clr_idx;

  logic                 rf_we;
  logic [REG_IDX_W-1:0] wr_idx;
  logic [WW-1:0]        wr_data;
  logic                 sp_up;
  logic                 pc_load;
  logic [WW-1:0]        pc_val;
  logic                 stk_we;
  logic [WW-1:0]        stk_wdata;
  logic                 bad_reg;
  logic                 o_valid, o_char;
  logic [IO_WORD_W-1:0] o_value;
  logic                 a_ok, ar_ok;
  logic [REG_IDX_W-1:0] rd_idx;
  logic [WW-1:0]        rd_val;

  logic                 stk_wr;
  logic [SAW-1:0]       stk_waddr;
  logic [WW-1:0]        stk_wd;

  logic pend_valid, pend_busy, out_free;
  res_t pend, pend_new;

  assign pc       = regs[REG_PC];
  assign sp       = regs[REG_SP];
  assign acc      = regs[REG_A];
  assign pc_plus  = pc + 1'b1;
  assign sp_plus  = sp + 1'b1;
  assign sp_minus = sp - 1'b1;

  assign op_dec = (prd < OP_LIMIT) ? opcode_t'(prd[3:0]) : OP_UNKNOWN;

  // program memory
  always_ff @(posedge clk) begin
    if (ctl.load_we) begin
      pmem[PAW'(cmd.load_address)] <= WW'(cmd.load_value);
    end
    prd <= pmem[pc[PAW-1:0]];
  end

  // stack memory
  assign stk_wr    = clearing || stk_we;
  assign stk_waddr = clearing ? clr_idx : sp_plus[SAW-1:0];
  assign stk_wd    = clearing ? '0 : stk_wdata;

  always_ff @(posedge clk) begin
    if (stk_wr) begin
      smem[stk_waddr] <= stk_wd;
    end
    srd <= smem[sp[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == STK_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // execute
  assign a_ok   = prd < NUM_REGS_W;
  assign ar_ok  = a_q < NUM_REGS_W;
  assign rd_idx = (op_q == OP_MOVE) ? a_q[REG_IDX_W-1:0] : prd[REG_IDX_W-1:0];
  assign rd_val = (rd_idx < NUM_REGS_I) ? regs[rd_idx] : '0;

  always_comb begin
    rf_we     = 1'b0;
    wr_idx    = prd[REG_IDX_W-1:0];
    wr_data   = srd;
    sp_up     = 1'b0;
    pc_load   = 1'b0;
    pc_val    = prd;
    stk_we    = 1'b0;
    stk_wdata = prd;
    bad_reg   = 1'b0;
    o_valid   = 1'b0;
    o_char    = 1'b0;
    o_value   = '0;
    if (ctl.exec) begin
      unique case (op_q)
        OP_PUSH: begin
          sp_up  = 1'b1;
          stk_we = 1'b1;
        end
        OP_POP: begin
          if (a_ok) begin
            rf_we = 1'b1;
          end else begin
            bad_reg = 1'b1;
          end
        end
        OP_ADD: begin
          rf_we   = 1'b1;
          wr_idx  = REG_A;
          wr_data = acc + prd;
        end
        OP_SUB: begin
          rf_we   = 1'b1;
          wr_idx  = REG_A;
          wr_data = acc - prd;
        end
        OP_SET: begin
          wr_idx  = a_q[REG_IDX_W-1:0];
          wr_data = prd;
          if (ar_ok) begin
            rf_we = 1'b1;
          end else begin
            bad_reg = 1'b1;
          end
        end
        OP_MOVE: begin
          wr_data = rd_val;
          if (ar_ok && a_ok) begin
            rf_we = 1'b1;
          end else begin
            bad_reg = 1'b1;
          end
        end
        OP_CALL: begin
          sp_up     = 1'b1;
          stk_we    = 1'b1;
          stk_wdata = pc;
          pc_load   = 1'b1;
        end
        OP_RET: begin
          pc_load = 1'b1;
          pc_val  = srd;
        end
        OP_BRZ: begin
          pc_load = (acc == '0);
        end
        OP_OUT, OP_OUTC: begin
          if (a_ok) begin
            o_valid = 1'b1;
            o_char  = (op_q == OP_OUTC);
            o_value = (op_q == OP_OUTC) ? IO_WORD_W'(rd_val[CHAR_W-1:0])
                                        : IO_WORD_W'(rd_val);
          end else begin
            bad_reg = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= (i == int'(REG_SP)) ? '1 : '0;
      end
    end else begin
      if (ctl.pc_inc) begin
        regs[REG_PC] <= pc_plus;
      end
      if (ctl.stk_pop) begin
        regs[REG_SP] <= sp_minus;
      end
      if (sp_up) begin
        regs[REG_SP] <= sp_plus;
      end
      if (pc_load) begin
        regs[REG_PC] <= pc_val;
      end
      if (rf_we) begin
        regs[wr_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b1;
      status_q <= ST_OK;
    end else begin
      if (ctl.halt) begin
        running <= 1'b0;
      end
      if (ctl.clear_status) begin
        status_q <= ST_OK;
      end else if (ctl.stk_pop && sp[WW-1]) begin
        status_q <= ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_op) begin
      op_q <= op_dec;
    end
    if (ctl.latch_a) begin
      a_q <= prd;
    end
  end

  // result staging: pending word, then output register
  assign status_now = bad_reg ? ST_BAD_REG : (ctl.clear_status ? ST_OK : status_q);
  assign out_free   = !res_valid || res_ready;
  assign pend_busy  = pend_valid && !out_free;

  always_comb begin
    pend_new.out_valid   = o_valid;
    pend_new.out_is_char = o_char;
    pend_new.out_value   = o_value;
    pend_new.halted      = !(running && !ctl.halt);
    pend_new.status      = status_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (pend_valid && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (ctl.finish) begin
        pend_valid <= 1'b1;
      end else if (out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      res <= pend;
    end
    if (ctl.finish) begin
      pend <= pend_new;
    end
  end

  always_comb begin
    stat.op_dec    = op_dec;
    stat.op_q      = op_q;
    stat.running   = running;
    stat.clearing  = clearing;
    stat.pend_busy = pend_busy;
  end

  `SVIS_ASSERT_NEXT(a_push_sp, ctl.exec && (op_q == OP_PUSH), sp == $past(sp) + 1'b1, "push did not advance SP")
  `SVIS_ASSERT_IMPL(a_pend_free, ctl.finish, !pend_busy, "pending result overwritten")

endmodule

`default_nettype wire

>>> rtl/stack_vm_instruction_step.sv
// ----------------------------------------------------------------------------
// stack_vm_instruction_step
// Stack machine that loads program words and executes one instruction a step.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (valid/ready) carries one word: a program load or an execute step.
//   res (valid/ready) returns exactly one result word per command word.
//   A load, or a step while halted, finishes in the idle state. A step
//   ends in decode (halt, unknown opcode), in the first operand state
//   (one-operand instructions, return) or in the second (set, move); the
//   single read port of the program memory fetches one word per cycle,
//   so each operand word has its own state. A pending word and an output
//   register sit between the sequencer and res, so a new command is taken
//   while a result waits; when the receiver stalls with both full,
//   cmd_ready drops until res is taken.
//   Reset (rst, synchronous) sets A-D and PC to zero, SP to all ones and the
//   machine running, then clears all STACK_DEPTH entries of the stack memory
//   (256 by default) with cmd_ready low. Program memory is not cleared;
//   depths must be powers of two, which the block does not check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_vm_instruction_step
  import svis_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 512,
  parameter int STACK_DEPTH   = 256,
  parameter int WORD_WIDTH    = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  svis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd.command),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  svis_dpath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire
